// ===== sv/sssp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared widths, codes, controller states and the command/status words that
// join the shortest-path controller and datapath.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int WEIGHT_W = 23;
  localparam int INDEX_W  = 5;
  localparam int COUNT_W  = 6;
  // wide enough to compare any index or count field against the vertex limit
  localparam int EXT_W    = 7;

  localparam logic [WEIGHT_W-1:0] NO_EDGE     = 23'h7fffff;
  localparam logic [COUNT_W-1:0]  COUNT_RESET = 6'd32;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_RUN   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_SEED_END,
    S_PICK,
    S_RELAX,
    S_RELAX_END,
    S_OUT_RD,
    S_OUT_LD
  } ctrl_state_t;

  typedef struct packed {
    logic wr_weight;
    logic capture;
    logic seed_issue;
    logic relax_issue;
    logic settle;
    logic idx_clr;
    logic out_issue;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic src_ok;
    logic idx_last;
    logic found;
    logic more_rounds;
    logic out_free;
    logic out_last;
  } dp_sts_t;

endpackage

// ===== sv/sssp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_in_if
// Request channel: weight writes and run requests.
// ----------------------------------------------------------------------------
interface sssp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [sssp_pkg::INDEX_W-1:0]   from_vertex;
  logic [sssp_pkg::INDEX_W-1:0]   to_vertex;
  logic [sssp_pkg::WEIGHT_W-1:0]  edge_weight;
  logic [sssp_pkg::INDEX_W-1:0]   source_vertex;

  modport source (output valid, req_type, from_vertex, to_vertex, edge_weight,
                  source_vertex, input ready);
  modport sink   (input valid, req_type, from_vertex, to_vertex, edge_weight,
                  source_vertex, output ready);
endinterface

// ===== sv/sssp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_out_if
// Result channel: one word per vertex distance.
// ----------------------------------------------------------------------------
interface sssp_out_if;
  logic                           valid;
  logic                           ready;
  logic [sssp_pkg::INDEX_W-1:0]   vertex_index;
  logic [sssp_pkg::WEIGHT_W-1:0]  distance;
  logic                           last_result;

  modport source (output valid, vertex_index, distance, last_result, input ready);
  modport sink   (input valid, vertex_index, distance, last_result, output ready);
endinterface

// ===== sv/sssp_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_cfg_if
// Configuration write channel for the vertex count register.
// ----------------------------------------------------------------------------
interface sssp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sssp_pkg::COUNT_W-1:0]  vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

// ===== sv/sssp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_ctrl
// Sequencer for seed, select/relax rounds and result drain.
// ----------------------------------------------------------------------------
module sssp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_req_type,
  input  sssp_pkg::dp_sts_t  sts,
  output logic               in_ready,
  output sssp_pkg::dp_cmd_t  cmd
);

  sssp_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sssp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sssp_pkg::S_IDLE: begin
        if (in_valid && (in_req_type == sssp_pkg::REQ_RUN) && sts.src_ok) begin
          state_nxt = sssp_pkg::S_SEED;
        end
      end
      sssp_pkg::S_SEED: begin
        if (sts.idx_last) state_nxt = sssp_pkg::S_SEED_END;
      end
      sssp_pkg::S_SEED_END:  state_nxt = sssp_pkg::S_PICK;
      sssp_pkg::S_PICK: begin
        if (sts.found && sts.more_rounds) state_nxt = sssp_pkg::S_RELAX;
        else state_nxt = sssp_pkg::S_OUT_RD;
      end
      sssp_pkg::S_RELAX: begin
        if (sts.idx_last) state_nxt = sssp_pkg::S_RELAX_END;
      end
      sssp_pkg::S_RELAX_END: state_nxt = sssp_pkg::S_PICK;
      sssp_pkg::S_OUT_RD: begin
        if (sts.out_free) state_nxt = sssp_pkg::S_OUT_LD;
      end
      sssp_pkg::S_OUT_LD: begin
        if (sts.out_last) state_nxt = sssp_pkg::S_IDLE;
        else state_nxt = sssp_pkg::S_OUT_RD;
      end
      default: state_nxt = sssp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      sssp_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.wr_weight = in_valid && (in_req_type == sssp_pkg::REQ_WRITE);
        cmd.capture   = in_valid && (in_req_type == sssp_pkg::REQ_RUN) && sts.src_ok;
      end
      sssp_pkg::S_SEED:  cmd.seed_issue = 1'b1;
      sssp_pkg::S_PICK: begin
        // settle the nearest open vertex, or start draining results
        if (sts.found && sts.more_rounds) cmd.settle = 1'b1;
        else cmd.idx_clr = 1'b1;
      end
      sssp_pkg::S_RELAX:  cmd.relax_issue = 1'b1;
      sssp_pkg::S_OUT_RD: cmd.out_issue   = sts.out_free;
      sssp_pkg::S_OUT_LD: cmd.out_load    = 1'b1;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/sssp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_dp
// Weight matrix and distance memories, sweep counter, relax/select stage
// and the result register.
// ----------------------------------------------------------------------------
module sssp_dp #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sssp_pkg::dp_cmd_t              cmd,
  output sssp_pkg::dp_sts_t              sts,
  input  logic [sssp_pkg::COUNT_W-1:0]   vertex_count,
  input  logic [sssp_pkg::INDEX_W-1:0]   in_from_vertex,
  input  logic [sssp_pkg::INDEX_W-1:0]   in_to_vertex,
  input  logic [sssp_pkg::WEIGHT_W-1:0]  in_edge_weight,
  input  logic [sssp_pkg::INDEX_W-1:0]   in_source_vertex,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sssp_pkg::INDEX_W-1:0]   out_vertex_index,
  output logic [sssp_pkg::WEIGHT_W-1:0]  out_distance,
  output logic                           out_last_result
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int AW     = 2 * VW;
  localparam int WDEPTH = 1 << AW;
  localparam int DDEPTH = 1 << VW;
  localparam int W      = sssp_pkg::WEIGHT_W;
  localparam int XW     = sssp_pkg::EXT_W;

  logic [W-1:0] wmem [WDEPTH];
  logic [W-1:0] dmem [DDEPTH];

  logic [VW-1:0]           src_r, idx_r, pick_r, least_idx_r, p_idx_r;
  logic [CW-1:0]           n_r, round_r;
  logic [W-1:0]            pick_dist_r, least_r;
  logic                    found_r, seed_d_r, relax_d_r;
  logic [MAX_VERTICES-1:0] settled_r;
  logic [W-1:0]            w_q, d_q;
  logic                    out_valid_r, out_last_r;
  logic [VW-1:0]           out_idx_r;
  logic [W-1:0]            out_dist_r;

  logic [CW-1:0] n_cur;
  logic [XW-1:0] vc_ext;
  logic          wr_ok;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [W:0]    via_sum;
  logic [W-1:0]  via, new_d;
  logic          stage_vld, unsettled, cand, d_we, upd_min;

  // clamp the configured count to 1..MAX_VERTICES
  always_comb begin
    vc_ext = XW'(vertex_count);
    if (vertex_count == '0) n_cur = CW'(1);
    else if (vc_ext > XW'(MAX_VERTICES)) n_cur = CW'(MAX_VERTICES);
    else n_cur = CW'(vertex_count);
  end

  assign wr_ok   = (XW'(in_from_vertex) < XW'(MAX_VERTICES)) &&
                   (XW'(in_to_vertex) < XW'(MAX_VERTICES));
  assign w_waddr = {VW'(in_from_vertex), VW'(in_to_vertex)};
  assign w_raddr = cmd.seed_issue ? {src_r, idx_r} : {pick_r, idx_r};

  always_ff @(posedge clk) begin
    if (cmd.wr_weight && wr_ok) wmem[w_waddr] <= in_edge_weight;
    w_q <= wmem[w_raddr];
  end

  // second stage: seed write, or relax through the settled pick
  assign via_sum   = {1'b0, pick_dist_r} + {1'b0, w_q};
  assign via       = (via_sum >= {1'b0, sssp_pkg::NO_EDGE}) ? sssp_pkg::NO_EDGE
                                                            : via_sum[W-1:0];
  assign stage_vld = seed_d_r || relax_d_r;
  assign unsettled = !settled_r[p_idx_r];

  always_comb begin
    if (seed_d_r) begin
      new_d = w_q;
      cand  = (p_idx_r != src_r);
    end else begin
      new_d = (d_q > via) ? via : d_q;
      cand  = unsettled;
    end
  end

  assign d_we    = seed_d_r || (relax_d_r && unsettled);
  assign upd_min = stage_vld && cand && (new_d < least_r);

  always_ff @(posedge clk) begin
    if (d_we) dmem[p_idx_r] <= new_d;
    d_q <= dmem[idx_r];
  end

  always_ff @(posedge clk) begin
    p_idx_r <= idx_r;
    if (cmd.capture) begin
      src_r   <= VW'(in_source_vertex);
      n_r     <= n_cur;
      idx_r   <= '0;
      round_r <= CW'(1);
      least_r <= sssp_pkg::NO_EDGE;
    end else if (cmd.settle) begin
      pick_r      <= least_idx_r;
      pick_dist_r <= least_r;
      least_r     <= sssp_pkg::NO_EDGE;
      idx_r       <= '0;
      round_r     <= round_r + CW'(1);
    end else begin
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.seed_issue || cmd.relax_issue || cmd.out_issue) idx_r <= idx_r + VW'(1);
      if (upd_min) begin
        least_r     <= new_d;
        least_idx_r <= p_idx_r;
      end
    end
    if (cmd.out_load) begin
      out_idx_r  <= p_idx_r;
      out_dist_r <= d_q;
      out_last_r <= sts.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      seed_d_r    <= 1'b0;
      relax_d_r   <= 1'b0;
      settled_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seed_d_r  <= cmd.seed_issue;
      relax_d_r <= cmd.relax_issue;
      if (cmd.capture || cmd.settle) found_r <= 1'b0;
      else if (upd_min) found_r <= 1'b1;
      if (cmd.settle) settled_r[least_idx_r] <= 1'b1;
      else if (seed_d_r) settled_r[p_idx_r] <= (p_idx_r == src_r);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.src_ok      = XW'(in_source_vertex) < XW'(n_cur);
    sts.idx_last    = (CW'(idx_r) == (n_r - CW'(1)));
    sts.found       = found_r;
    sts.more_rounds = (round_r < n_r);
    sts.out_free    = !out_valid_r || out_ready;
    sts.out_last    = (CW'(p_idx_r) == (n_r - CW'(1)));
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = sssp_pkg::INDEX_W'(out_idx_r);
  assign out_distance     = out_dist_r;
  assign out_last_result  = out_last_r;

endmodule

// ===== sv/single_source_shortest_paths.sv =====
`timescale 1ns / 1ps
// Weight write: one word per cycle, accepted whenever the block is idle.
// Run: a seed sweep, then select/relax rounds over the n active vertices, then the
//   results; selection stops early when no open vertex is reachable. Each result
//   word is read, then loaded once the output register is free.
// Intake is held from run acceptance until the last result is loaded.
// Synchronous active-low reset: idle, settled marks clear, count = 32; memories uncleared.
// ----------------------------------------------------------------------------
// single_source_shortest_paths
// Dense-graph shortest paths from one source over a loaded weight matrix.
// ----------------------------------------------------------------------------
module single_source_shortest_paths #(
  parameter int MAX_VERTICES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sssp_in_if.sink    in_ch,
  sssp_out_if.source out_ch,
  sssp_cfg_if.sink   cfg_ch
);

  logic [sssp_pkg::COUNT_W-1:0] vertex_count_r;
  sssp_pkg::dp_cmd_t            cmd;
  sssp_pkg::dp_sts_t            sts;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= sssp_pkg::COUNT_RESET;
    end else if (cfg_ch.valid) begin
      vertex_count_r <= cfg_ch.vertex_count;
    end
  end

  sssp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .sts         (sts),
    .in_ready    (in_ch.ready),
    .cmd         (cmd)
  );

  sssp_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .vertex_count     (vertex_count_r),
    .in_from_vertex   (in_ch.from_vertex),
    .in_to_vertex     (in_ch.to_vertex),
    .in_edge_weight   (in_ch.edge_weight),
    .in_source_vertex (in_ch.source_vertex),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_vertex_index (out_ch.vertex_index),
    .out_distance     (out_ch.distance),
    .out_last_result  (out_ch.last_result)
  );

  // only a vertex that won the selection sweep may be settled
  a_settle_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.settle |-> sts.found)
    else $error("settle without a selected vertex");

  // a result word is loaded only after its distance read was issued
  a_load_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> $past(cmd.out_issue))
    else $error("result loaded without a distance read");

  // intake stays closed while a sweep is running
  a_sweep_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.seed_issue || cmd.relax_issue) |-> !in_ch.ready)
    else $error("request accepted during a sweep");

endmodule
